// ===== design/wta_pkg.sv =====
`timescale 1ns / 1ps
package wta_pkg;

  localparam int TILE_SHIFT = 6;
  localparam int FRAC_BITS  = 8;

  localparam int COORD_W    = 24;
  localparam int PIX_W      = 12;
  localparam int FACE_W     = 2;
  localparam int TEX_IDX_W  = 10;
  localparam int TEX_SIZE_W = 11;
  localparam int STRIDE_W   = 16;
  localparam int BPP_W      = 3;
  localparam int OFF_W      = 26;
  localparam int CFG_DATA_W = 16;

  localparam int POS_W      = TILE_SHIFT + FRAC_BITS;
  localparam int POS_PROD_W = POS_W + TEX_SIZE_W;
  localparam int ROW_FX_W   = PIX_W + FRAC_BITS;
  localparam int D_W        = ((ROW_FX_W > COORD_W) ? ROW_FX_W : COORD_W) + 2;
  localparam int Q_W        = TEX_SIZE_W;
  localparam int NUM_W      = COORD_W + Q_W;
  localparam int COLB_W     = TEX_IDX_W + BPP_W;

  localparam logic [TEX_SIZE_W-1:0] TEX_WIDTH_RST  = TEX_SIZE_W'(64);
  localparam logic [TEX_SIZE_W-1:0] TEX_HEIGHT_RST = TEX_SIZE_W'(64);
  localparam logic [STRIDE_W-1:0]   ROW_STRIDE_RST = STRIDE_W'(256);
  localparam logic [BPP_W-1:0]      BPP_RST        = BPP_W'(4);

  localparam logic [1:0] FACE_WEST  = 2'd0;
  localparam logic [1:0] FACE_EAST  = 2'd1;
  localparam logic [1:0] FACE_NORTH = 2'd2;
  localparam logic [1:0] FACE_SOUTH = 2'd3;

  typedef enum logic [1:0] {
    REG_TEX_WIDTH  = 2'd0,
    REG_TEX_HEIGHT = 2'd1,
    REG_ROW_STRIDE = 2'd2,
    REG_BPP        = 2'd3
  } wta_reg_t;

  typedef struct packed {
    logic [TEX_SIZE_W-1:0] tex_width;
    logic [TEX_SIZE_W-1:0] tex_height;
    logic [STRIDE_W-1:0]   row_stride;
    logic [BPP_W-1:0]      texel_bytes;
  } wta_cfg_t;

  typedef struct packed {
    logic [FACE_W-1:0]    face;
    logic [TEX_IDX_W-1:0] col;
    logic [PIX_W-1:0]     pcol;
    logic [PIX_W-1:0]     prow;
    logic                 row_zero;
    logic                 row_full;
  } wta_side_t;

  function automatic logic [TEX_IDX_W-1:0] idx_max(input logic [TEX_SIZE_W-1:0] size);
    logic [TEX_IDX_W-1:0] m;
    if (size == '0) begin
      m = '0;
    end else if (size >= TEX_SIZE_W'(1 << TEX_IDX_W)) begin
      m = '1;
    end else begin
      m = size[TEX_IDX_W-1:0] - TEX_IDX_W'(1);
    end
    return m;
  endfunction

endpackage

// ===== design/wta_in_if.sv =====
`timescale 1ns / 1ps
interface wta_in_if;
  import wta_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      hit_vertical;
  logic                      facing_right;
  logic                      facing_down;
  logic [COORD_W-1:0]        hit_x;
  logic [COORD_W-1:0]        hit_y;
  logic [PIX_W-1:0]          pixel_column;
  logic [PIX_W-1:0]          pixel_row;
  logic signed [COORD_W-1:0] strip_top;
  logic [COORD_W-1:0]        strip_height;

  modport source (
    output valid, hit_vertical, facing_right, facing_down, hit_x, hit_y,
           pixel_column, pixel_row, strip_top, strip_height,
    input  ready
  );

  modport sink (
    input  valid, hit_vertical, facing_right, facing_down, hit_x, hit_y,
           pixel_column, pixel_row, strip_top, strip_height,
    output ready
  );
endinterface

// ===== design/wta_out_if.sv =====
`timescale 1ns / 1ps
interface wta_out_if;
  import wta_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [FACE_W-1:0]    face;
  logic [TEX_IDX_W-1:0] texel_column;
  logic [TEX_IDX_W-1:0] texel_row;
  logic [OFF_W-1:0]     texel_offset;
  logic [PIX_W-1:0]     out_column;
  logic [PIX_W-1:0]     out_row;

  modport source (
    output valid, face, texel_column, texel_row, texel_offset, out_column, out_row,
    input  ready
  );

  modport sink (
    input  valid, face, texel_column, texel_row, texel_offset, out_column, out_row,
    output ready
  );
endinterface

// ===== design/wta_front.sv =====
`timescale 1ns / 1ps
module wta_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  wta_pkg::wta_cfg_t                 cfg,
  input  logic                              in_valid,
  input  logic                              hit_vertical,
  input  logic                              facing_right,
  input  logic                              facing_down,
  input  logic [wta_pkg::COORD_W-1:0]       hit_x,
  input  logic [wta_pkg::COORD_W-1:0]       hit_y,
  input  logic [wta_pkg::PIX_W-1:0]         pixel_column,
  input  logic [wta_pkg::PIX_W-1:0]         pixel_row,
  input  logic signed [wta_pkg::COORD_W-1:0] strip_top,
  input  logic [wta_pkg::COORD_W-1:0]       strip_height,
  output logic                              div_valid,
  output logic [wta_pkg::NUM_W-1:0]         div_num,
  output logic [wta_pkg::NUM_W-1:0]         div_den,
  output wta_pkg::wta_side_t                div_side
);
  import wta_pkg::*;

  logic                     s1_valid;
  logic [FACE_W-1:0]        s1_face;
  logic [POS_PROD_W-1:0]    s1_pos_prod;
  logic signed [D_W-1:0]    s1_d;
  logic [COORD_W-1:0]       s1_height;
  logic [PIX_W-1:0]         s1_pcol;
  logic [PIX_W-1:0]         s1_prow;

  logic [FACE_W-1:0]        face_next;
  logic [POS_W-1:0]         pos;
  logic [POS_PROD_W-1:0]    pos_prod_next;
  logic signed [D_W-1:0]    d_next;

  logic [TEX_SIZE_W-1:0]    col_raw;
  logic [TEX_IDX_W-1:0]     col_max;
  logic [TEX_IDX_W-1:0]     col_next;
  logic                     row_zero_next;
  logic                     row_full_next;
  logic [NUM_W-1:0]         num_next;

  always_comb begin
    if (hit_vertical) begin
      face_next = facing_right ? FACE_WEST : FACE_EAST;
    end else begin
      face_next = facing_down ? FACE_NORTH : FACE_SOUTH;
    end
    pos = hit_vertical ? hit_y[POS_W-1:0] : hit_x[POS_W-1:0];
    pos_prod_next = POS_PROD_W'(pos) * POS_PROD_W'(cfg.tex_width);
    d_next = $signed({{(D_W-ROW_FX_W){1'b0}}, pixel_row, {FRAC_BITS{1'b0}}})
           - $signed({{(D_W-COORD_W){strip_top[COORD_W-1]}}, strip_top});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
    if (en) begin
      s1_face     <= face_next;
      s1_pos_prod <= pos_prod_next;
      s1_d        <= d_next;
      s1_height   <= strip_height;
      s1_pcol     <= pixel_column;
      s1_prow     <= pixel_row;
    end
  end

  always_comb begin
    col_raw = s1_pos_prod[POS_PROD_W-1:POS_W];
    col_max = idx_max(cfg.tex_width);
    col_next = (col_raw > TEX_SIZE_W'(col_max)) ? col_max : col_raw[TEX_IDX_W-1:0];
    row_zero_next = (s1_height == '0) || s1_d[D_W-1] || (s1_d == '0);
    row_full_next = !row_zero_next
                  && (s1_d[D_W-2:0] >= (D_W-1)'(s1_height));
    if (row_zero_next || row_full_next) begin
      num_next = '0;
    end else begin
      num_next = NUM_W'(s1_d[COORD_W-1:0]) * NUM_W'(cfg.tex_height);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_valid <= 1'b0;
    end else if (en) begin
      div_valid <= s1_valid;
    end
    if (en) begin
      div_num           <= num_next;
      div_den           <= NUM_W'({s1_height, {(Q_W-1){1'b0}}});
      div_side.face     <= s1_face;
      div_side.col      <= col_next;
      div_side.pcol     <= s1_pcol;
      div_side.prow     <= s1_prow;
      div_side.row_zero <= row_zero_next;
      div_side.row_full <= row_full_next;
    end
  end

endmodule

// ===== design/wta_divider.sv =====
`timescale 1ns / 1ps
module wta_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [wta_pkg::NUM_W-1:0] num,
  input  logic [wta_pkg::NUM_W-1:0] den,
  input  wta_pkg::wta_side_t        in_side,
  output logic                      out_valid,
  output logic [wta_pkg::Q_W-1:0]   quot,
  output wta_pkg::wta_side_t        out_side
);
  import wta_pkg::*;

  logic [NUM_W-1:0] rem   [Q_W-1];
  logic [NUM_W-1:0] dsr   [Q_W-1];
  logic [Q_W-1:0]   q     [Q_W];
  wta_side_t        side  [Q_W];
  logic             valid [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    logic [NUM_W-1:0] r_in;
    logic [NUM_W-1:0] d_in;
    logic [Q_W-1:0]   q_in;
    wta_side_t        s_in;
    logic             v_in;
    logic             ge;

    if (i == 0) begin : g_first
      assign r_in = num;
      assign d_in = den;
      assign q_in = '0;
      assign s_in = in_side;
      assign v_in = in_valid;
    end else begin : g_next
      assign r_in = rem[i-1];
      assign d_in = dsr[i-1];
      assign q_in = q[i-1];
      assign s_in = side[i-1];
      assign v_in = valid[i-1];
    end

    assign ge = (r_in >= d_in);

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i] <= 1'b0;
      end else if (en) begin
        valid[i] <= v_in;
      end
      if (en) begin
        q[i]    <= {q_in[Q_W-2:0], ge};
        side[i] <= s_in;
      end
    end

    if (i < Q_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[i] <= ge ? (r_in - d_in) : r_in;
          dsr[i] <= d_in >> 1;
        end
      end
    end
  end

  assign out_valid = valid[Q_W-1];
  assign quot      = q[Q_W-1];
  assign out_side  = side[Q_W-1];

endmodule

// ===== design/wta_back.sv =====
`timescale 1ns / 1ps
module wta_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  wta_pkg::wta_cfg_t             cfg,
  input  logic                          in_valid,
  input  logic [wta_pkg::Q_W-1:0]       quot,
  input  wta_pkg::wta_side_t            in_side,
  output logic                          out_valid,
  output logic [wta_pkg::FACE_W-1:0]    face,
  output logic [wta_pkg::TEX_IDX_W-1:0] texel_column,
  output logic [wta_pkg::TEX_IDX_W-1:0] texel_row,
  output logic [wta_pkg::OFF_W-1:0]     texel_offset,
  output logic [wta_pkg::PIX_W-1:0]     out_column,
  output logic [wta_pkg::PIX_W-1:0]     out_row
);
  import wta_pkg::*;

  logic                 a_valid;
  logic [TEX_IDX_W-1:0] a_row;
  logic [FACE_W-1:0]    a_face;
  logic [TEX_IDX_W-1:0] a_col;
  logic [PIX_W-1:0]     a_pcol;
  logic [PIX_W-1:0]     a_prow;

  logic                 b_valid;
  logic [OFF_W-1:0]     b_row_off;
  logic [COLB_W-1:0]    b_col_off;
  logic [TEX_IDX_W-1:0] b_row;
  logic [FACE_W-1:0]    b_face;
  logic [TEX_IDX_W-1:0] b_col;
  logic [PIX_W-1:0]     b_pcol;
  logic [PIX_W-1:0]     b_prow;

  logic [TEX_IDX_W-1:0] row_max;
  logic [TEX_IDX_W-1:0] row_next;

  always_comb begin
    row_max = idx_max(cfg.tex_height);
    if (in_side.row_zero) begin
      row_next = '0;
    end else if (in_side.row_full || (quot > Q_W'(row_max))) begin
      row_next = row_max;
    end else begin
      row_next = quot[TEX_IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      out_valid <= b_valid;
    end
    if (en) begin
      a_row  <= row_next;
      a_face <= in_side.face;
      a_col  <= in_side.col;
      a_pcol <= in_side.pcol;
      a_prow <= in_side.prow;

      b_row_off <= OFF_W'(a_row) * OFF_W'(cfg.row_stride);
      b_col_off <= COLB_W'(a_col) * COLB_W'(cfg.texel_bytes);
      b_row     <= a_row;
      b_face    <= a_face;
      b_col     <= a_col;
      b_pcol    <= a_pcol;
      b_prow    <= a_prow;

      texel_offset <= b_row_off + OFF_W'(b_col_off);
      texel_row    <= b_row;
      texel_column <= b_col;
      face         <= b_face;
      out_column   <= b_pcol;
      out_row      <= b_prow;
    end
  end

endmodule

// ===== design/wall_texel_address_mapper.sv =====
`timescale 1ns / 1ps
// Texel addressing for raycast wall pixels. One transaction per clock is taken
// while the output is not stalled. The front end picks the face, the column
// and the fixed-point row distance, an 11-stage restoring divider forms the
// row (one quotient bit per stage), and the back end clamps the row, forms the
// byte offset and holds the result in the output register. A stall on the
// output freezes the whole pipeline; nothing is lost or repeated. Texture
// registers are written through cfg_we, cfg_index and cfg_data; the user must
// write them only while the pipeline is empty; the block does not enforce it.
module wall_texel_address_mapper (
  input  logic                           clk,
  input  logic                           rst,
  wta_in_if.sink                         pix_in,
  wta_out_if.source                      tex_out,
  input  logic                           cfg_we,
  input  wta_pkg::wta_reg_t              cfg_index,
  input  logic [wta_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wta_pkg::*;

  wta_cfg_t         cfg;
  logic             en;
  logic             div_in_valid;
  logic [NUM_W-1:0] div_num;
  logic [NUM_W-1:0] div_den;
  wta_side_t        div_in_side;
  logic             div_out_valid;
  logic [Q_W-1:0]   quot;
  wta_side_t        div_out_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tex_width   <= TEX_WIDTH_RST;
      cfg.tex_height  <= TEX_HEIGHT_RST;
      cfg.row_stride  <= ROW_STRIDE_RST;
      cfg.texel_bytes <= BPP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEX_WIDTH:  cfg.tex_width   <= cfg_data[TEX_SIZE_W-1:0];
        REG_TEX_HEIGHT: cfg.tex_height  <= cfg_data[TEX_SIZE_W-1:0];
        REG_ROW_STRIDE: cfg.row_stride  <= cfg_data[STRIDE_W-1:0];
        REG_BPP:        cfg.texel_bytes <= cfg_data[BPP_W-1:0];
        default: ;
      endcase
    end
  end

  // advance unless a finished result is waiting
  assign en           = !tex_out.valid || tex_out.ready;
  assign pix_in.ready = en && !rst;

  wta_front u_front (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .cfg          (cfg),
    .in_valid     (pix_in.valid),
    .hit_vertical (pix_in.hit_vertical),
    .facing_right (pix_in.facing_right),
    .facing_down  (pix_in.facing_down),
    .hit_x        (pix_in.hit_x),
    .hit_y        (pix_in.hit_y),
    .pixel_column (pix_in.pixel_column),
    .pixel_row    (pix_in.pixel_row),
    .strip_top    (pix_in.strip_top),
    .strip_height (pix_in.strip_height),
    .div_valid    (div_in_valid),
    .div_num      (div_num),
    .div_den      (div_den),
    .div_side     (div_in_side)
  );

  wta_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (div_in_valid),
    .num       (div_num),
    .den       (div_den),
    .in_side   (div_in_side),
    .out_valid (div_out_valid),
    .quot      (quot),
    .out_side  (div_out_side)
  );

  wta_back u_back (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .cfg          (cfg),
    .in_valid     (div_out_valid),
    .quot         (quot),
    .in_side      (div_out_side),
    .out_valid    (tex_out.valid),
    .face         (tex_out.face),
    .texel_column (tex_out.texel_column),
    .texel_row    (tex_out.texel_row),
    .texel_offset (tex_out.texel_offset),
    .out_column   (tex_out.out_column),
    .out_row      (tex_out.out_row)
  );

endmodule
